FILE: hw/rtl/fsc_pkg.sv
// fsc_pkg: shared types and constants of the frequency stability checker
// used by fsc_ctrl, fsc_datapath and frequency_stability_checker
package fsc_pkg;

  localparam int FREQ_W   = 16;
  localparam int ROC_W    = 24;
  localparam int PROD_W   = 48;
  localparam int QUO_W    = 25;
  localparam int REM_W    = 17;
  localparam int CNT_W    = 5;

  localparam logic [CNT_W-1:0]  DIV_LAST_CNT   = CNT_W'(QUO_W - 1);
  localparam logic [QUO_W-1:0]  ROC_CLAMP_HIGH = QUO_W'(25600);
  localparam logic [QUO_W-1:0]  ROC_LOW_MAG    = QUO_W'(8388608);
  localparam logic [FREQ_W-1:0] LOW_FREQ_RESET = 16'd12544;
  localparam logic [FREQ_W-1:0] ROC_THR_RESET  = 16'd2560;

  // register index, taken from paddr[2]
  localparam logic REG_LOW_FREQ = 1'b0;
  localparam logic REG_ROC_THR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN
  } fsc_state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic div_init;
    logic div_step;
    logic finish;
  } fsc_cmd_t;

  typedef struct packed {
    logic div_last;
  } fsc_status_t;

endpackage

FILE: hw/rtl/fsc_ctrl.sv
// fsc_ctrl: sequencer of the frequency stability checker
// depends on fsc_pkg; drives fsc_datapath through fsc_cmd_t
module fsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fsc_pkg::fsc_status_t status,
  output fsc_pkg::fsc_cmd_t    cmd
);
  import fsc_pkg::*;

  fsc_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        // wait for the output register to be free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish)     out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

endmodule

FILE: hw/rtl/fsc_datapath.sv
// fsc_datapath: multiplier, restoring divider, clamp and stability flags
// depends on fsc_pkg; sequenced by fsc_ctrl
module fsc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  fsc_pkg::fsc_cmd_t             cmd,
  output fsc_pkg::fsc_status_t          status,
  input  logic [fsc_pkg::FREQ_W-1:0]   freq_sample,
  input  logic                         maintenance_mode,
  input  logic                         monitoring_active,
  input  logic                         loads_switched_on,
  input  logic [fsc_pkg::FREQ_W-1:0]   low_freq_threshold,
  input  logic [fsc_pkg::FREQ_W-1:0]   roc_threshold,
  output logic signed [fsc_pkg::ROC_W-1:0] roc,
  output logic                         unstable_flag,
  output logic                         shed_request,
  output logic                         timing_reset
);
  import fsc_pkg::*;

  logic [FREQ_W-1:0] prev_frequency;
  logic              unstable_state;
  logic [FREQ_W-1:0] freq;
  logic              maint, monitoring, loads;
  logic [FREQ_W-1:0] diff;
  logic [REM_W-1:0]  sum;
  logic              neg;
  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;

  logic [31:0]       mul1_res;
  logic [PROD_W-1:0] mul2_res;
  logic [REM_W:0]    trial;
  logic              fits;
  logic [ROC_W-1:0]  roc_val;
  logic [ROC_W-1:0]  abs_roc;
  logic              unstable;
  logic              flag_next;

  assign mul1_res = 32'(diff) * 32'(freq);
  assign mul2_res = PROD_W'(prod[31:0]) * PROD_W'(prev_frequency);

  // one quotient bit per step
  assign trial = {rem, quo[QUO_W-1]};
  assign fits  = trial >= {1'b0, sum};

  assign status.div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_frequency <= '0;
      unstable_state <= 1'b0;
    end else if (cmd.finish) begin
      prev_frequency <= freq;
      unstable_state <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq       <= freq_sample;
      maint      <= maintenance_mode;
      monitoring <= monitoring_active;
      loads      <= loads_switched_on;
      neg        <= freq_sample < prev_frequency;
      diff       <= (freq_sample >= prev_frequency) ? freq_sample - prev_frequency
                                                    : prev_frequency - freq_sample;
      sum        <= REM_W'(freq_sample) + REM_W'(prev_frequency);
    end
    if (cmd.mul1) prod <= PROD_W'(mul1_res);
    if (cmd.mul2) prod <= mul2_res;
    if (cmd.div_init) begin
      // dividend is prod >> 7; quotient is known to fit in QUO_W bits
      rem <= REM_W'(prod[PROD_W-1:32]);
      quo <= prod[31:7];
      cnt <= DIV_LAST_CNT;
    end
    if (cmd.div_step) begin
      rem <= fits ? REM_W'(trial - {1'b0, sum}) : trial[REM_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
    if (cmd.finish) begin
      roc           <= roc_val;
      unstable_flag <= flag_next;
      shed_request  <= unstable && !maint && !monitoring && loads;
      timing_reset  <= !unstable;
    end
  end

  // clamp and sign
  always_comb begin
    if (sum == '0) begin
      roc_val = '0;
      abs_roc = '0;
    end else if (neg) begin
      if (quo > ROC_LOW_MAG) abs_roc = ROC_LOW_MAG[ROC_W-1:0];
      else                   abs_roc = quo[ROC_W-1:0];
      roc_val = -abs_roc;
    end else begin
      if (quo > ROC_CLAMP_HIGH) abs_roc = ROC_CLAMP_HIGH[ROC_W-1:0];
      else                      abs_roc = quo[ROC_W-1:0];
      roc_val = abs_roc;
    end
  end

  assign unstable = (freq < low_freq_threshold) || (abs_roc > ROC_W'(roc_threshold));

  always_comb begin
    if (!unstable)  flag_next = 1'b0;
    else if (maint) flag_next = unstable_state;
    else            flag_next = 1'b1;
  end

endmodule

FILE: hw/rtl/frequency_stability_checker.sv
// frequency_stability_checker: rate of change and grid stability flags
// each word passes the load, two multiply steps, the divider setup, the 25-step
// restoring divider and the finish step; a new word is taken only in idle,
// so the block works on one word at a time
// the next word is taken while a finished result still waits downstream
// reset: synchronous active high; clears previous sample, flag and thresholds to defaults
module frequency_stability_checker (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] freq_sample
  input  logic [2:0]  s_tuser,   // [0] maintenance_mode, [1] monitoring_active,
                                 // [2] loads_switched_on
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] roc
  output logic [2:0]  m_tuser,   // [0] unstable_flag, [1] shed_request, [2] timing_reset
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fsc_pkg::*;

  fsc_cmd_t    cmd;
  fsc_status_t status;

  logic [FREQ_W-1:0] low_freq_threshold;
  logic [FREQ_W-1:0] roc_threshold;
  logic              cfg_write;
  logic signed [ROC_W-1:0] roc;

  // configuration registers, register index from paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_freq_threshold <= LOW_FREQ_RESET;
      roc_threshold      <= ROC_THR_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_LOW_FREQ: low_freq_threshold <= pwdata[FREQ_W-1:0];
        REG_ROC_THR:  roc_threshold      <= pwdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LOW_FREQ: prdata = {16'b0, low_freq_threshold};
      REG_ROC_THR:  prdata = {16'b0, roc_threshold};
      default:      prdata = '0;
    endcase
  end

  // sequencer: one word at a time through multiply and divide
  fsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath also holds the output register
  fsc_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .freq_sample        (s_tdata),
    .maintenance_mode   (s_tuser[0]),
    .monitoring_active  (s_tuser[1]),
    .loads_switched_on  (s_tuser[2]),
    .low_freq_threshold (low_freq_threshold),
    .roc_threshold      (roc_threshold),
    .roc                (roc),
    .unstable_flag      (m_tuser[0]),
    .shed_request       (m_tuser[1]),
    .timing_reset       (m_tuser[2])
  );

  assign m_tdata = roc;

endmodule

FILE: hw/rtl/fsc_checker.sv
// fsc_checker: port-level assertions of frequency_stability_checker
// bound to the top level; no package needed
module fsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in progress");

  // a shed request always comes with the unstable flag set
  a_shed_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && !m_tuser[2])
    else $error("shed request without unstable flag");

  // rate is clamped at 100.0
  a_roc_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata) <= $signed(24'd25600))
    else $error("rate above clamp");

endmodule

bind frequency_stability_checker fsc_checker u_fsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/sv/tb.sv
// tb: self-checking bench for frequency_stability_checker, with its own rate and flag predictor
// depends on fsc_pkg for the register index codes and on the block's stream and apb ports
module tb;
  import fsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;   // quiet time after the last word has come back, before the summary

  // one result word as the block reports it
  typedef struct {
    logic [23:0] roc;
    logic        unstable_flag;
    logic        shed_request;
    logic        timing_reset;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] freq_sample
  logic [2:0]  s_tuser = '0;   // [0] maintenance_mode, [1] monitoring_active,
                               // [2] loads_switched_on
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [23:0] roc
  logic [2:0]  m_tuser;        // [0] unstable_flag, [1] shed_request, [2] timing_reset
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the block's registers and state
  logic [15:0] low_freq_thr = LOW_FREQ_RESET;
  logic [15:0] roc_thr = ROC_THR_RESET;
  logic [15:0] last_freq = '0;
  logic        unstable_now = 1'b0;

  reading_t pending_readings[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int error_count = 0;
  int samples_sent = 0;
  int readings_checked = 0;
  int thresholds_written = 0;
  int cycle_count = 0;

  frequency_stability_checker i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // rate of change in q16.8: (f - p) * 2 * f * p / ((f + p) * 256), magnitude truncated,
  // clamped above at 100.0 and below at the most negative 24-bit value
  function automatic logic [23:0] rate_of_change(input logic [15:0] f, input logic [15:0] p);
    longint unsigned fw, pw, sum, diff, mag;
    longint signed r;
    bit neg;
    fw = f;
    pw = p;
    sum = fw + pw;
    if (sum == 0) return 24'd0;
    neg = (fw < pw);
    diff = neg ? (pw - fw) : (fw - pw);
    mag = (diff * 2 * fw * pw) / (sum * 256);
    r = neg ? -longint'(mag) : longint'(mag);
    if (r > 25600) r = 25600;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  // works out the word the block should return for one accepted sample and advances state
  function automatic reading_t predict_reading(input logic [15:0] freq, input logic maint,
                                               input logic monitoring, input logic loads);
    reading_t rd;
    int signed roc_val;
    int unsigned roc_mag;
    logic unstable;
    rd.roc = rate_of_change(freq, last_freq);
    roc_val = $signed(rd.roc);
    roc_mag = (roc_val < 0) ? -roc_val : roc_val;
    unstable = (freq < low_freq_thr) || (roc_mag > roc_thr);
    rd.shed_request = 1'b0;
    rd.timing_reset = 1'b0;
    if (unstable) begin
      // maintenance mode freezes the flag and blocks any shed
      if (!maint) begin
        rd.shed_request = !monitoring && loads;
        unstable_now = 1'b1;
      end
    end else begin
      unstable_now = 1'b0;
      rd.timing_reset = 1'b1;
    end
    rd.unstable_flag = unstable_now;
    last_freq = freq;
    return rd;
  endfunction

  // drives one sample word, with random idle cycles ahead of it, and waits for the handshake
  task automatic send_sample(input logic [15:0] freq, input logic maint,
                             input logic monitoring, input logic loads);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= freq;
    s_tuser <= {loads, monitoring, maint};
    do @(posedge clk); while (!s_tready);
    pending_readings.push_back(predict_reading(freq, maint, monitoring, loads));
    samples_sent++;
  endtask

  // waits until every predicted word has come back, with the input stream quiet
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle; the register takes the value at the access edge
  task automatic write_threshold(input logic reg_idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_LOW_FREQ) low_freq_thr = value;
    else roc_thr = value;
    thresholds_written++;
  endtask

  // random sample: mostly small steps from the last one so both stable and unstable
  // readings show up, with some jumps, repeats and full-range noise mixed in
  task automatic send_random_sample();
    int f;
    case ($urandom_range(19))
      0, 1:    f = $urandom_range(65535);
      2, 3:    f = last_freq;
      4, 5, 6: f = $urandom_range(11500, 14000);
      default: f = int'(last_freq) + $urandom_range(160) - 80;
    endcase
    if (f < 0) f = 0;
    if (f > 65535) f = 65535;
    send_sample(f[15:0], $urandom_range(7) == 0, 1'($urandom_range(1)),
                1'($urandom_range(1)));
  endtask

  // extremes of the fields and the corner cases of the rate and flag logic
  task automatic test_directed();
    send_sample(16'd0, 1'b0, 1'b0, 1'b0);       // first word after reset, previous taken as 0
    send_sample(16'd0, 1'b0, 1'b0, 1'b1);       // both samples zero, divisor zero
    send_sample(16'd12800, 1'b0, 1'b0, 1'b1);   // 50 hz after zero: product zero, stable
    send_sample(16'd12800, 1'b0, 1'b1, 1'b1);
    send_sample(16'd12820, 1'b0, 1'b0, 1'b1);   // small drift under the rate limit
    send_sample(16'd13800, 1'b0, 1'b0, 1'b1);   // jump over the rate limit, shed
    send_sample(16'd13800, 1'b0, 1'b0, 1'b1);
    send_sample(16'd12000, 1'b1, 1'b0, 1'b1);   // unstable in maintenance, flag stays clear
    send_sample(16'd12000, 1'b0, 1'b0, 1'b1);   // low frequency sets the flag
    send_sample(16'd11990, 1'b1, 1'b0, 1'b1);   // maintenance keeps the flag set
    send_sample(16'd12543, 1'b0, 1'b1, 1'b1);   // monitoring already on, no shed
    send_sample(16'd12544, 1'b0, 1'b0, 1'b0);
    send_sample(16'd12544, 1'b0, 1'b0, 1'b1);   // exactly at the frequency limit
    send_sample(16'd65535, 1'b0, 1'b0, 1'b1);
    send_sample(16'd65535, 1'b0, 1'b0, 1'b1);
    send_sample(16'd1, 1'b0, 1'b0, 1'b1);       // steep fall, negative rate
    send_sample(16'd32768, 1'b0, 1'b0, 1'b1);   // steep rise from near zero, rate stays small and under the limit
    send_sample(16'd65535, 1'b0, 1'b0, 1'b1);
    send_sample(16'd0, 1'b0, 1'b0, 1'b1);       // drop to zero, product zero
    send_sample(16'd65535, 1'b1, 1'b1, 1'b1);
    send_sample(16'd0, 1'b1, 1'b1, 1'b0);
    wait_drained();
  endtask

  // threshold registers at their extremes and exactly at a measured rate
  task automatic test_thresholds();
    logic [15:0] step_mag;
    int signed step_roc;
    write_threshold(REG_LOW_FREQ, 16'h0000);   // no frequency is too low; only a steep fall can exceed the rate limit
    write_threshold(REG_ROC_THR, 16'hffff);
    repeat (15) send_random_sample();
    wait_drained();
    write_threshold(REG_LOW_FREQ, 16'hffff);   // everything below full scale is unstable
    write_threshold(REG_ROC_THR, 16'h0000);
    send_sample(16'd65535, 1'b0, 1'b0, 1'b1);
    send_sample(16'd65535, 1'b0, 1'b0, 1'b1);
    repeat (13) send_random_sample();
    wait_drained();
    // rate limit equal to the step's rate: stable; one below: unstable
    step_roc = $signed(rate_of_change(16'd12810, 16'd12800));
    step_mag = 16'(step_roc);
    write_threshold(REG_LOW_FREQ, LOW_FREQ_RESET);
    write_threshold(REG_ROC_THR, step_mag);
    send_sample(16'd12800, 1'b0, 1'b0, 1'b1);
    send_sample(16'd12810, 1'b0, 1'b0, 1'b1);
    wait_drained();
    write_threshold(REG_ROC_THR, step_mag - 16'd1);
    send_sample(16'd12800, 1'b0, 1'b0, 1'b1);
    send_sample(16'd12810, 1'b0, 1'b0, 1'b1);
    wait_drained();
  endtask

  // one run of random samples under a given idle pattern and random thresholds
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    wait_drained();
    write_threshold(REG_LOW_FREQ, 16'($urandom_range(11800, 13000)));
    write_threshold(REG_ROC_THR, 16'($urandom_range(256, 5000)));
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (count) send_random_sample();
    wait_drained();
  endtask

  // result side: random backpressure, and each accepted word checked against the oldest
  // prediction; the handshake is judged on the values held before the edge
  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_readings.size() == 0) begin
          $error("result word with no sample pending: roc %0d, tuser %b",
                 $signed(m_tdata), m_tuser);
          error_count++;
        end else begin
          want = pending_readings.pop_front();
          readings_checked++;
          if (m_tdata !== want.roc) begin
            $error("roc: expected %0d, got %0d", $signed(want.roc), $signed(m_tdata));
            error_count++;
          end
          if (m_tuser[0] !== want.unstable_flag) begin
            $error("unstable_flag: expected %0b, got %0b", want.unstable_flag, m_tuser[0]);
            error_count++;
          end
          if (m_tuser[1] !== want.shed_request) begin
            $error("shed_request: expected %0b, got %0b", want.shed_request, m_tuser[1]);
            error_count++;
          end
          if (m_tuser[2] !== want.timing_reset) begin
            $error("timing_reset: expected %0b, got %0b", want.timing_reset, m_tuser[2]);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_readings.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_random_phase(38, 84, 290);   // slow sender, very slow receiver
    test_random_phase(84, 38, 290);   // the other way round
    test_random_phase(0, 0, 290);     // back to back
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d samples, checked %0d result words, %0d threshold writes",
             samples_sent, readings_checked, thresholds_written);
    $display("covered zero and full-scale samples, clamping, maintenance and threshold edges");
    if (error_count == 0 && pending_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
